[design/gcdlcm_pkg.sv]
// Package for the GCD and LCM unit: widths, word types, the request and
// response structs of the iterative units, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package gcdlcm_pkg;

  localparam int unsigned FieldW = 16;
  localparam int unsigned OpW    = 16;
  localparam int unsigned MultW  = 2 * OpW;
  localparam int unsigned ShiftW = $clog2(OpW);
  localparam int unsigned CountW = $clog2(OpW + 1);

  typedef logic [OpW-1:0] operand_t;

  typedef struct packed {
    logic [FieldW-1:0] first_value;
    logic [FieldW-1:0] second_value;
  } in_word_t;

  typedef struct packed {
    logic [FieldW-1:0] divisor;
    logic [MultW-1:0]  multiple;
  } out_word_t;

  typedef struct packed {
    logic     start;
    operand_t lhs;
    operand_t rhs;
  } unit_req_t;

  typedef struct packed {
    logic     done;
    operand_t result;
  } unit_rsp_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StGcd  = 5'b00010,
    StDiv  = 5'b00100,
    StMul  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

endpackage

[design/gcd_lcm_unit.sv]
// Top level of the GCD and LCM unit: sequencer, multiplier and output register.
// Depends on gcdlcm_pkg, gcdlcm_gcd and gcdlcm_div.
`timescale 1ns / 1ps

// The unit takes one word at a time and returns the greatest common divisor
// and the least common multiple of its two operands. When either operand is
// zero the GCD loop is skipped and the word goes straight to the output state.
// Otherwise the binary GCD loop runs first, one shift or subtract per cycle;
// a restoring divider then forms first / divisor, and one registered multiply
// gives the multiple. The unit takes no new word until the current one has
// moved to the output register, which holds a finished word while the next
// one is being worked on.

module gcd_lcm_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gcdlcm_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gcdlcm_pkg::out_word_t out_word_o
);

  gcdlcm_pkg::state_e     state_q, state_d;
  gcdlcm_pkg::operand_t   a_q, a_d, b_q, b_d, g_q, g_d;
  logic [gcdlcm_pkg::MultW-1:0] prod_q, prod_d;
  gcdlcm_pkg::unit_req_t  gcd_req, div_req;
  gcdlcm_pkg::unit_rsp_t  gcd_rsp, div_rsp;
  gcdlcm_pkg::operand_t   in_a, in_b;
  logic                   in_fire, out_load;
  logic                   out_valid_q, out_valid_d;
  gcdlcm_pkg::out_word_t  out_word_q, out_word_d;

  assign in_a     = in_word_i.first_value[gcdlcm_pkg::OpW-1:0];
  assign in_b     = in_word_i.second_value[gcdlcm_pkg::OpW-1:0];
  assign in_ready_o = (state_q == gcdlcm_pkg::StIdle);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_load = (state_q == gcdlcm_pkg::StOut) && (!out_valid_q || out_ready_i);

  gcdlcm_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .rsp_o  (gcd_rsp)
  );

  gcdlcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d       = state_q;
    a_d           = a_q;
    b_d           = b_q;
    g_d           = g_q;
    prod_d        = prod_q;
    gcd_req.start = 1'b0;
    gcd_req.lhs   = in_a;
    gcd_req.rhs   = in_b;
    div_req.start = 1'b0;
    div_req.lhs   = a_q;
    div_req.rhs   = gcd_rsp.result;
    case (state_q)
      gcdlcm_pkg::StIdle: begin
        if (in_fire) begin
          a_d = in_a;
          b_d = in_b;
          if (in_a == '0 || in_b == '0) begin
            g_d     = gcdlcm_pkg::OpW'(1);
            prod_d  = '0;
            state_d = gcdlcm_pkg::StOut;
          end else begin
            gcd_req.start = 1'b1;
            state_d       = gcdlcm_pkg::StGcd;
          end
        end
      end
      gcdlcm_pkg::StGcd: begin
        if (gcd_rsp.done) begin
          g_d           = gcd_rsp.result;
          div_req.start = 1'b1;
          state_d       = gcdlcm_pkg::StDiv;
        end
      end
      gcdlcm_pkg::StDiv: begin
        if (div_rsp.done) begin
          state_d = gcdlcm_pkg::StMul;
        end
      end
      gcdlcm_pkg::StMul: begin
        prod_d  = gcdlcm_pkg::MultW'(div_rsp.result) * gcdlcm_pkg::MultW'(b_q);
        state_d = gcdlcm_pkg::StOut;
      end
      gcdlcm_pkg::StOut: begin
        if (out_load) begin
          state_d = gcdlcm_pkg::StIdle;
        end
      end
      default: begin
        state_d = gcdlcm_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d         = 1'b1;
      out_word_d.divisor  = g_q;
      out_word_d.multiple = prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcdlcm_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    g_q        <= g_d;
    prod_q     <= prod_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[design/gcdlcm_gcd.sv]
// Binary GCD unit: one subtract, compare or shift step per cycle.
// Depends on gcdlcm_pkg.
`timescale 1ns / 1ps

module gcdlcm_gcd (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gcdlcm_pkg::unit_req_t req_i,
  output gcdlcm_pkg::unit_rsp_t rsp_o
);

  gcdlcm_pkg::operand_t             a_q, a_d, b_q, b_d;
  logic [gcdlcm_pkg::ShiftW-1:0]    k_q, k_d;
  logic                             busy_q, busy_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    busy_d = busy_q;
    if (req_i.start) begin
      a_d    = req_i.lhs;
      b_d    = req_i.rhs;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (a_q == '0) begin
        busy_d = 1'b0;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = (a_q - b_q) >> 1;
      end else begin
        b_d = (b_q - a_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  assign rsp_o.done   = busy_q && (a_q == '0);
  assign rsp_o.result = b_q << k_q;

endmodule

[design/gcdlcm_div.sv]
// Restoring divider: one quotient bit per cycle.
// Depends on gcdlcm_pkg.
`timescale 1ns / 1ps

module gcdlcm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gcdlcm_pkg::unit_req_t req_i,
  output gcdlcm_pkg::unit_rsp_t rsp_o
);

  gcdlcm_pkg::operand_t          rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [gcdlcm_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic [gcdlcm_pkg::OpW:0]      trial;
  logic                          fits;

  assign trial = {rem_q, quo_q[gcdlcm_pkg::OpW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.lhs;
      den_d  = req_i.rhs;
      cnt_d  = gcdlcm_pkg::CountW'(gcdlcm_pkg::OpW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        rem_d = fits ? gcdlcm_pkg::OpW'(trial - {1'b0, den_q})
                     : gcdlcm_pkg::OpW'(trial);
        quo_d = {quo_q[gcdlcm_pkg::OpW-2:0], fits};
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done   = busy_q && (cnt_q == '0);
  assign rsp_o.result = quo_q;

endmodule

[verif/tb_gcd_lcm_unit.sv]
// Self-checking testbench for gcd_lcm_unit: drives operand pairs under random
// idling on both sides and checks each result against its own GCD/LCM predictor.
// Depends on gcdlcm_pkg and the gcd_lcm_unit design.
`timescale 1ns / 1ps

module tb_gcd_lcm_unit;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned PhaseWords = 417;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  gcdlcm_pkg::in_word_t  in_word_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  gcdlcm_pkg::out_word_t out_word_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  int unsigned words_sent;

  class gcd_lcm_scoreboard;
    gcdlcm_pkg::out_word_t results_due[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned zero_pairs;

    function new();
      mismatches   = 0;
      results_seen = 0;
      zero_pairs   = 0;
    endfunction

    function gcdlcm_pkg::out_word_t gcd_lcm_of(gcdlcm_pkg::in_word_t w);
      gcdlcm_pkg::operand_t  a;
      gcdlcm_pkg::operand_t  b;
      gcdlcm_pkg::operand_t  x;
      gcdlcm_pkg::operand_t  y;
      gcdlcm_pkg::operand_t  r;
      logic [63:0]           prod;
      gcdlcm_pkg::out_word_t res;
      a = w.first_value[gcdlcm_pkg::OpW-1:0];
      b = w.second_value[gcdlcm_pkg::OpW-1:0];
      res.divisor  = gcdlcm_pkg::FieldW'(1);
      res.multiple = '0;
      if (a != 0 && b != 0) begin
        x = a;
        y = b;
        while (y != 0) begin
          r = x % y;
          x = y;
          y = r;
        end
        prod = (64'(a) / 64'(x)) * 64'(b);
        res.divisor  = gcdlcm_pkg::FieldW'(x);
        res.multiple = prod[gcdlcm_pkg::MultW-1:0];
      end
      return res;
    endfunction

    function void note_pair(gcdlcm_pkg::in_word_t w);
      if (w.first_value == 0 || w.second_value == 0) begin
        zero_pairs++;
      end
      results_due.push_back(gcd_lcm_of(w));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 20) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    task check_word(gcdlcm_pkg::out_word_t got);
      gcdlcm_pkg::out_word_t want;
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word divisor=%0d multiple=%0d",
                                  got.divisor, got.multiple));
      end else begin
        want = results_due.pop_front();
        if (got.divisor !== want.divisor) begin
          report_mismatch($sformatf("divisor %0d, expected %0d",
                                    got.divisor, want.divisor));
        end
        if (got.multiple !== want.multiple) begin
          report_mismatch($sformatf("multiple %0d, expected %0d",
                                    got.multiple, want.multiple));
        end
      end
    endtask

    function int unsigned pending();
      return results_due.size();
    endfunction
  endclass

  gcd_lcm_scoreboard sb;

  gcd_lcm_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles.", cycle_count);
    $display("gcd_lcm_unit test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_pair(in_word_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(out_word_o);
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic gcdlcm_pkg::in_word_t make_pair(logic [15:0] a, logic [15:0] b);
    gcdlcm_pkg::in_word_t w;
    w.first_value  = a;
    w.second_value = b;
    return w;
  endfunction

  function automatic gcdlcm_pkg::in_word_t random_pair();
    gcdlcm_pkg::in_word_t w;
    int unsigned          kind;
    int unsigned          g;
    kind = $urandom_range(9);
    w.first_value  = 16'($urandom);
    w.second_value = 16'($urandom);
    case (kind)
      4, 5: begin
        g = $urandom_range(1, 255);
        w.first_value  = 16'(g * $urandom_range(0, 65535 / g));
        w.second_value = 16'(g * $urandom_range(0, 65535 / g));
      end
      6: begin
        w.first_value  = 16'($urandom_range(0, 20));
        w.second_value = 16'($urandom_range(0, 20));
      end
      7: begin
        w.second_value = w.first_value;
      end
      8: begin
        if ($urandom_range(1)) begin
          w.first_value = '0;
        end else begin
          w.second_value = '0;
        end
      end
      9: begin
        w.first_value  = w.first_value << $urandom_range(15);
        w.second_value = w.second_value << $urandom_range(15);
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  task automatic send_pair(input gcdlcm_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pair(random_pair());
  endtask

  initial begin
    gcdlcm_pkg::in_word_t directed[$];
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 57;
    words_sent    = 0;

    directed = '{
      make_pair(16'h0000, 16'h0000), make_pair(16'h0000, 16'h0005),
      make_pair(16'h0005, 16'h0000), make_pair(16'h0000, 16'hFFFF),
      make_pair(16'hFFFF, 16'h0000), make_pair(16'h0001, 16'h0001),
      make_pair(16'hFFFF, 16'hFFFF), make_pair(16'h0001, 16'hFFFF),
      make_pair(16'hFFFF, 16'h0001), make_pair(16'hFFFE, 16'hFFFF),
      make_pair(16'h0007, 16'h0007), make_pair(16'h000C, 16'h0012),
      make_pair(16'h8000, 16'h8000), make_pair(16'h8000, 16'h4000),
      make_pair(16'hFFF1, 16'hFFEF), make_pair(16'h8000, 16'h0003),
      make_pair(16'hFF00, 16'h00FF), make_pair(16'hAAAA, 16'h5555),
      make_pair(16'h0400, 16'h0001), make_pair(16'hFFFF, 16'hFF00)
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_pair(directed[i]);
    send_random(PhaseWords);

    send_idle_pct = 57;
    recv_idle_pct = 36;
    send_random(PhaseWords);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(PhaseWords);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d operand pairs (%0d with a zero operand) and checked %0d results.",
             words_sent, sb.zero_pairs, sb.results_seen);
    $display("Idling covered sender-heavy, receiver-heavy and back-to-back phases.");
    if (sb.mismatches == 0) begin
      $display("gcd_lcm_unit test passed");
    end else begin
      $display("%0d mismatches found.", sb.mismatches);
      $display("gcd_lcm_unit test failed");
    end
    $finish;
  end

endmodule
